// ===== hw/rtl/rcf_pkg.sv =====
package rcf_pkg;

   localparam int FILE_HEADER_BYTES = 12;
   localparam int QUEUE_DEPTH = 9;
   localparam logic [31:0] DROP_ID_RESET = 32'h4A55_4E4B;

   localparam logic [1:0] ENTRY_BYTE   = 2'd0;
   localparam logic [1:0] ENTRY_BURST  = 2'd1;
   localparam logic [1:0] ENTRY_STATUS = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        status;
      logic [63:0] data;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage

// ===== hw/rtl/riff_chunk_filter.sv =====
// RIFF chunk filter: passes a RIFF/WAV byte stream and removes every chunk
// whose four-byte id equals csr_write_data as last written (reset "JUNK").
// Input channel req_*: one transfer per byte (opcode 0) or end of file
// (opcode 1). One byte is taken per cycle while req_stall is low.
// Result channel rsp_*: one transfer per output byte, a status transfer
// (end_of_file high) closes each file. last_of_run marks the final result
// of an input transfer; a kept chunk header comes out as a burst of eight.
// A byte that yields a result passes through the entry queue and then the
// output register before it is on rsp_*. Sustained rate is one transfer per
// cycle on each side while req_stall and rsp_stall are low; the back end
// emits one result per cycle while rsp_stall is low, so the eight-byte
// header bursts are absorbed by the entry queue.
// req_stall rises only when the entry queue is full, which happens while
// the receiver holds rsp_stall high; results are held, never dropped.
// Reset (synchronous, active high) clears the parser, queue and output
// register and loads the reset drop id; no clearing pass is needed.
// csr_write_enable writes the drop id; write it only when idle.
module riff_chunk_filter #(
   parameter int QUEUE_DEPTH = rcf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_end_of_file,
   output logic        rsp_status,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   rcf_pkg::q_status_type q_status;
   rcf_pkg::entry_type    push_entry;
   rcf_pkg::entry_type    head_entry;
   logic                  push;
   logic                  pop;
   logic [2:0]            burst_index;

   rcf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_in_byte      (req_in_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   rcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_status   (q_status),
      .head_entry (head_entry)
   );

   rcf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head_entry      (head_entry),
      .pop             (pop),
      .burst_index     (burst_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_end_of_file (rsp_end_of_file),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("entry pushed into a full queue");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("pop from an empty queue");

   a_burst_holds_head: assert property (@(posedge clock) disable iff (reset)
      (burst_index != 3'd0) |->
         (q_status.valid && (head_entry.kind == rcf_pkg::ENTRY_BURST)))
      else $error("header burst lost its queue entry");

   a_status_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_file) |-> (rsp_last_of_run && !rsp_byte_valid))
      else $error("status result not marked as last, or marked as data");

endmodule

// ===== hw/rtl/rcf_front.sv =====
module rcf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [7:0]           req_in_byte,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   input  rcf_pkg::q_status_type q_status,
   output logic                 push,
   output rcf_pkg::entry_type   push_entry
);

   localparam logic [1:0] PH_FILE = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [63:0] head_bytes_ff, head_bytes_in;
   logic [2:0]  head_index_ff, head_index_in;
   logic [32:0] remaining_ff, remaining_in;
   logic        dropping_ff, dropping_in;
   logic [31:0] drop_id_ff;

   logic        accept;
   logic [3:0]  header_count_next;
   logic [63:0] head_full;
   logic [31:0] chunk_size;
   logic [32:0] padded;
   logic [32:0] remaining_dec;

   assign req_stall = q_status.full;
   assign accept = req_valid && !q_status.full;

   assign header_count_next = header_count_ff + 4'd1;
   assign head_full = {head_bytes_ff[55:0], req_in_byte};
   assign chunk_size = {head_full[7:0], head_full[15:8], head_full[23:16], head_full[31:24]};
   assign padded = {1'b0, chunk_size} + {32'd0, chunk_size[0]};
   assign remaining_dec = (remaining_ff != 33'd0) ? remaining_ff - 33'd1 : remaining_ff;

   always_comb begin
      phase_in = phase_ff;
      header_count_in = header_count_ff;
      head_bytes_in = head_bytes_ff;
      head_index_in = head_index_ff;
      remaining_in = remaining_ff;
      dropping_in = dropping_ff;
      push = 1'b0;
      push_entry = '0;
      if (accept) begin
         if (req_opcode) begin
            push = 1'b1;
            push_entry.kind = rcf_pkg::ENTRY_STATUS;
            push_entry.status = (phase_ff == PH_FILE);
            phase_in = PH_FILE;
            header_count_in = 4'd0;
            head_bytes_in = 64'd0;
            head_index_in = 3'd0;
            remaining_in = 33'd0;
            dropping_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_FILE: begin
                  push = 1'b1;
                  push_entry.kind = rcf_pkg::ENTRY_BYTE;
                  push_entry.data = {56'd0, req_in_byte};
                  if (header_count_next >= 4'(rcf_pkg::FILE_HEADER_BYTES)) begin
                     phase_in = PH_HEAD;
                     header_count_in = 4'd0;
                  end else begin
                     header_count_in = header_count_next;
                  end
               end
               PH_BODY: begin
                  if (!dropping_ff) begin
                     push = 1'b1;
                     push_entry.kind = rcf_pkg::ENTRY_BYTE;
                     push_entry.data = {56'd0, req_in_byte};
                  end
                  remaining_in = remaining_dec;
                  if (remaining_dec == 33'd0) begin
                     phase_in = PH_HEAD;
                     dropping_in = 1'b0;
                  end
               end
               default: begin
                  if (head_index_ff != 3'd7) begin
                     head_bytes_in = head_full;
                     head_index_in = head_index_ff + 3'd1;
                  end else begin
                     if (head_full[63:32] == drop_id_ff) begin
                        dropping_in = 1'b1;
                     end else begin
                        dropping_in = 1'b0;
                        push = 1'b1;
                        push_entry.kind = rcf_pkg::ENTRY_BURST;
                        push_entry.data = head_full;
                     end
                     head_bytes_in = 64'd0;
                     head_index_in = 3'd0;
                     remaining_in = padded;
                     if (padded == 33'd0) begin
                        phase_in = PH_HEAD;
                        dropping_in = 1'b0;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FILE;
         header_count_ff <= 4'd0;
         head_bytes_ff <= 64'd0;
         head_index_ff <= 3'd0;
         remaining_ff <= 33'd0;
         dropping_ff <= 1'b0;
         drop_id_ff <= rcf_pkg::DROP_ID_RESET;
      end else begin
         phase_ff <= phase_in;
         header_count_ff <= header_count_in;
         head_bytes_ff <= head_bytes_in;
         head_index_ff <= head_index_in;
         remaining_ff <= remaining_in;
         dropping_ff <= dropping_in;
         if (csr_write_enable) begin
            drop_id_ff <= csr_write_data;
         end
      end
   end

endmodule

// ===== hw/rtl/rcf_queue.sv =====
module rcf_queue #(
   parameter int DEPTH = rcf_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rcf_pkg::entry_type    push_entry,
   input  logic                  pop,
   output rcf_pkg::q_status_type q_status,
   output rcf_pkg::entry_type    head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rcf_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.valid = (count_ff != '0);
   assign q_status.full = (count_ff == CNT_W'(DEPTH));
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/rcf_back.sv =====
module rcf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rcf_pkg::q_status_type q_status,
   input  rcf_pkg::entry_type    head_entry,
   output logic                  pop,
   output logic [2:0]            burst_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_end_of_file,
   output logic                  rsp_status,
   output logic                  rsp_last_of_run
);

   logic       valid_ff, valid_in;
   logic [2:0] index_ff, index_in;
   logic [7:0] byte_ff, byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       eof_ff, eof_in;
   logic       status_ff, status_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_burst;

   assign load = q_status.valid && (!valid_ff || !rsp_stall);
   assign is_burst = (head_entry.kind == rcf_pkg::ENTRY_BURST);
   assign pop = load && (!is_burst || (index_ff == 3'd7));
   assign valid_in = load || (valid_ff && rsp_stall);
   assign index_in = (load && is_burst) ? index_ff + 3'd1 : index_ff;

   always_comb begin
      case (head_entry.kind)
         rcf_pkg::ENTRY_BURST: begin
            byte_in = head_entry.data[{~index_ff, 3'b000} +: 8];
            byte_valid_in = 1'b1;
            eof_in = 1'b0;
            status_in = 1'b0;
            last_in = (index_ff == 3'd7);
         end
         rcf_pkg::ENTRY_STATUS: begin
            byte_in = 8'd0;
            byte_valid_in = 1'b0;
            eof_in = 1'b1;
            status_in = head_entry.status;
            last_in = 1'b1;
         end
         default: begin
            byte_in = head_entry.data[7:0];
            byte_valid_in = 1'b1;
            eof_in = 1'b0;
            status_in = 1'b0;
            last_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         byte_valid_ff <= byte_valid_in;
         eof_ff <= eof_in;
         status_ff <= status_in;
         last_ff <= last_in;
      end
   end

   assign burst_index = index_ff;
   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_end_of_file = eof_ff;
   assign rsp_status = status_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== sim/riff_chunk_filter_tb.sv =====
module riff_chunk_filter_tb;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOF = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_SHORT_HEADER = 1'b1;
   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_WAVE = 32'h5741_5645;
   localparam logic [31:0] ID_LIST = 32'h4C49_5354;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 190;
   localparam int CALM_TAIL = 40;

   typedef enum logic [1:0] {
      IN_FILE_HEADER,
      IN_CHUNK_HEADER,
      IN_CHUNK_BODY
   } parse_phase_type;

   typedef enum logic [1:0] {
      STEP_SEND,
      STEP_WRITE_ID,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic          opcode;
      logic [7:0]    data;
      logic [31:0]   drop_id;
      bit            paced;
   } step_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_file;
      logic       status;
      logic       last_of_run;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_BYTE;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_end_of_file;
   logic        rsp_status;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = 32'h0;

   step_type   pending[$];
   result_type filtered_due[$];

   logic [31:0]     model_drop_id = rcf_pkg::DROP_ID_RESET;
   parse_phase_type model_phase = IN_FILE_HEADER;
   logic [3:0]      model_header_count = 4'd0;
   logic [63:0]     model_head = 64'h0;
   logic [2:0]      model_head_index = 3'd0;
   logic [32:0]     model_remaining = 33'h0;
   logic            model_dropping = 1'b0;

   logic [31:0] gen_drop_id;
   bit          gen_paced;
   bit          calm = 1'b1;
   int          sent_items = 0;
   int          gap_left = 0;
   int          settle_count = 0;
   int          stall_left = 0;
   int          mismatches = 0;
   int          cycles = 0;

   riff_chunk_filter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_end_of_file (rsp_end_of_file),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial begin : run_clock
      forever #5 clock = ~clock;
   end

   initial begin : run_reset
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   task clear_parse();
      model_phase = IN_FILE_HEADER;
      model_header_count = 4'd0;
      model_head = 64'h0;
      model_head_index = 3'd0;
      model_remaining = 33'h0;
      model_dropping = 1'b0;
   endtask

   task due_result(input logic [7:0] b, input logic bv, input logic eof, input logic st,
                   input logic last);
      filtered_due.push_back({b, bv, eof, st, last});
   endtask

   task predict_filtered(input logic op, input logic [7:0] b);
      logic [31:0] size;
      logic [32:0] padded;
      if (op == OP_EOF) begin
         due_result(8'h00, 1'b0, 1'b1,
                    (model_phase == IN_FILE_HEADER) ? STATUS_SHORT_HEADER : STATUS_OK, 1'b1);
         clear_parse();
      end else begin
         case (model_phase)
            IN_FILE_HEADER: begin
               due_result(b, 1'b1, 1'b0, STATUS_OK, 1'b1);
               model_header_count = model_header_count + 4'd1;
               if (model_header_count >= rcf_pkg::FILE_HEADER_BYTES) begin
                  model_phase = IN_CHUNK_HEADER;
                  model_header_count = 4'd0;
               end
            end
            IN_CHUNK_BODY: begin
               if (!model_dropping)
                  due_result(b, 1'b1, 1'b0, STATUS_OK, 1'b1);
               if (model_remaining != 0)
                  model_remaining = model_remaining - 33'd1;
               if (model_remaining == 0) begin
                  model_phase = IN_CHUNK_HEADER;
                  model_dropping = 1'b0;
               end
            end
            default: begin
               model_head = {model_head[55:0], b};
               if (model_head_index != 3'd7) begin
                  model_head_index = model_head_index + 3'd1;
               end else begin
                  size = {model_head[7:0], model_head[15:8], model_head[23:16],
                          model_head[31:24]};
                  padded = {1'b0, size} + {32'd0, size[0]};
                  if (model_head[63:32] == model_drop_id) begin
                     model_dropping = 1'b1;
                  end else begin
                     model_dropping = 1'b0;
                     for (int i = 0; i < 8; i++)
                        due_result(model_head[63 - 8 * i -: 8], 1'b1, 1'b0, STATUS_OK, i == 7);
                  end
                  model_head = 64'h0;
                  model_head_index = 3'd0;
                  model_remaining = padded;
                  if (padded == 0) begin
                     model_phase = IN_CHUNK_HEADER;
                     model_dropping = 1'b0;
                  end else begin
                     model_phase = IN_CHUNK_BODY;
                  end
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : drive_req
      logic        next_valid;
      logic        next_opcode;
      logic [7:0]  next_byte;
      logic        next_we;
      logic [31:0] next_wdata;
      next_valid = req_valid;
      next_opcode = req_opcode;
      next_byte = req_in_byte;
      next_we = 1'b0;
      next_wdata = csr_write_data;
      if (reset) begin
         next_valid = 1'b0;
         clear_parse();
         model_drop_id = rcf_pkg::DROP_ID_RESET;
         gap_left = 0;
         settle_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_filtered(req_opcode, req_in_byte);
            next_valid = 1'b0;
            if (!calm && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 3);
         end
         if (filtered_due.size() == 0 && !req_valid)
            settle_count++;
         else
            settle_count = 0;
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending.size() != 0) begin
               case (pending[0].kind)
                  STEP_SEND: begin
                     next_valid = 1'b1;
                     next_opcode = pending[0].opcode;
                     next_byte = pending[0].data;
                     calm = !pending[0].paced;
                     void'(pending.pop_front());
                  end
                  default: begin
                     if (settle_count >= SETTLE_CYCLES) begin
                        if (pending[0].kind == STEP_WRITE_ID) begin
                           next_we = 1'b1;
                           next_wdata = pending[0].drop_id;
                           model_drop_id = pending[0].drop_id;
                           settle_count = 0;
                        end
                        void'(pending.pop_front());
                     end
                  end
               endcase
            end else begin
               calm = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
      req_opcode <= next_opcode;
      req_in_byte <= next_byte;
      csr_write_enable <= next_we;
      csr_write_data <= next_wdata;
   end

   always @(posedge clock) begin : check_rsp
      result_type seen;
      result_type due;
      logic       next_stall;
      next_stall = 1'b0;
      if (reset) begin
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_out_byte, rsp_byte_valid, rsp_end_of_file, rsp_status, rsp_last_of_run};
            if (filtered_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: byte %h valid %b eof %b status %b last %b",
                           seen.out_byte, seen.byte_valid, seen.end_of_file, seen.status,
                           seen.last_of_run);
            end else begin
               due = filtered_due.pop_front();
               if (seen !== due) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected byte %h valid %b eof %b status %b last %b,",
                               " got byte %h valid %b eof %b status %b last %b"},
                              due.out_byte, due.byte_valid, due.end_of_file, due.status,
                              due.last_of_run, seen.out_byte, seen.byte_valid,
                              seen.end_of_file, seen.status, seen.last_of_run);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            next_stall = 1'b1;
         end
      end
      rsp_stall <= next_stall;
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[riff_chunk_filter] ERROR");
         $finish;
      end
   end

   task queue_step(input step_kind_type kind, input logic op, input logic [7:0] b,
                   input logic [31:0] id);
      step_type s;
      s.kind = kind;
      s.opcode = op;
      s.data = b;
      s.drop_id = id;
      s.paced = gen_paced;
      pending.push_back(s);
   endtask

   task send(input logic op, input logic [7:0] b);
      queue_step(STEP_SEND, op, b, 32'h0);
      sent_items++;
   endtask

   task write_drop_id(input logic [31:0] id);
      queue_step(STEP_WRITE_ID, OP_BYTE, 8'h00, id);
      gen_drop_id = id;
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task send_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--)
         send(OP_BYTE, w[8 * i +: 8]);
   endtask

   task send_chunk_head(input logic [31:0] id, input logic [31:0] size);
      send_word(id);
      send_word({size[7:0], size[15:8], size[23:16], size[31:24]});
   endtask

   task send_file_header();
      if ($urandom_range(0, 3) == 0) begin
         repeat (rcf_pkg::FILE_HEADER_BYTES) send(OP_BYTE, rand_byte());
      end else begin
         send_word(ID_RIFF);
         send_word($urandom);
         send_word(ID_WAVE);
      end
   endtask

   task send_random_file();
      logic [31:0] id;
      logic [31:0] size;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, rcf_pkg::FILE_HEADER_BYTES - 1)) send(OP_BYTE, rand_byte());
         send(OP_EOF, rand_byte());
         return;
      end
      send_file_header();
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 4))
            0, 1: id = gen_drop_id;
            2: id = gen_drop_id ^ (32'h1 << $urandom_range(0, 31));
            default: id = $urandom;
         endcase
         size = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom_range(1, 9);
         send_chunk_head(id, size);
         repeat (size + size[0]) send(OP_BYTE, rand_byte());
      end
      case ($urandom_range(0, 5))
         0: repeat ($urandom_range(1, 7)) send(OP_BYTE, rand_byte());
         1: begin
            id = $urandom_range(0, 1) ? gen_drop_id : ID_LIST;
            case ($urandom_range(0, 2))
               0: size = 32'hFFFF_FFFF;
               1: size = 32'h8000_0000;
               default: size = $urandom | 32'h100;
            endcase
            send_chunk_head(id, size);
            repeat ($urandom_range(0, 4)) send(OP_BYTE, rand_byte());
         end
         default: ;
      endcase
      send(OP_EOF, rand_byte());
   endtask

   initial begin : build_stimulus
      int files;
      int directed_items;
      gen_drop_id = rcf_pkg::DROP_ID_RESET;
      gen_paced = 1'b1;

      send(OP_EOF, 8'hFF);
      send(OP_BYTE, 8'h00);
      send(OP_BYTE, 8'hFF);
      repeat (rcf_pkg::FILE_HEADER_BYTES - 2) send(OP_BYTE, rand_byte());
      send_chunk_head(rcf_pkg::DROP_ID_RESET, 32'h0);
      send_chunk_head(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_BYTE, 8'h80);
      send(OP_EOF, 8'h00);
      directed_items = sent_items;

      files = 0;
      while (sent_items < directed_items + RANDOM_ITEMS) begin
         gen_paced = $urandom_range(0, 3) != 0;
         if (files == 0)
            write_drop_id(32'h0000_0000);
         else if (files == 1)
            write_drop_id(32'hFFFF_FFFF);
         else if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 3))
               0: write_drop_id(rcf_pkg::DROP_ID_RESET);
               1: write_drop_id(ID_LIST);
               default: write_drop_id($urandom);
            endcase
         if (files == 3 || $urandom_range(0, 7) == 0)
            queue_step(STEP_DRAIN, OP_BYTE, 8'h00, 32'h0);
         send_random_file();
         files++;
      end
      for (int i = pending.size() - CALM_TAIL; i < pending.size(); i++)
         if (i >= 0)
            pending[i].paced = 1'b0;

      @(negedge clock);
      while (pending.size() != 0 || req_valid || filtered_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && filtered_due.size() == 0)
         $display("[riff_chunk_filter] OK");
      else
         $display("[riff_chunk_filter] ERROR");
      $finish;
   end

endmodule
